FILE: src/elevator_car_controller_top_assert.svh
// Assertion macros for the elevator car controller.
`ifndef ELEVATOR_CAR_CONTROLLER_TOP_ASSERT_SVH
`define ELEVATOR_CAR_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ECC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ECC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ecc_pkg.sv
// Package: types, codes and helpers for the elevator car controller.
package ecc_pkg;

  localparam int FLOORS      = 4;
  localparam int FLOOR_W     = 3;
  localparam int REMOTE_W    = 4;
  localparam int MASK_W      = 4;
  localparam int HOLD_W      = 16;
  localparam int STATE_W     = 3;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  localparam logic [HOLD_W-1:0]  DOOR_HOLD_RESET = HOLD_W'(40);
  localparam logic [FLOOR_W-1:0] FLOOR_RESET     = FLOOR_W'(4);

  // Car state codes as seen on the result stream.
  localparam logic [STATE_W-1:0] CODE_IDLE  = 3'd0;
  localparam logic [STATE_W-1:0] CODE_UP    = 3'd1;
  localparam logic [STATE_W-1:0] CODE_DOWN  = 3'd2;
  localparam logic [STATE_W-1:0] CODE_OPEN  = 3'd3;
  localparam logic [STATE_W-1:0] CODE_EMERG = 3'd4;

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_UP    = 5'b00010,
    MODE_DOWN  = 5'b00100,
    MODE_OPEN  = 5'b01000,
    MODE_EMERG = 5'b10000
  } mode_t;

  // One-hot mask for a floor number; zero when outside 1..FLOORS.
  function automatic logic [MASK_W-1:0] floor_onehot(input logic [REMOTE_W-1:0] f);
    logic [MASK_W-1:0] m;
    m = '0;
    for (int i = 0; i < FLOORS; i++) begin
      m[i] = (f == REMOTE_W'(i + 1));
    end
    return m;
  endfunction

endpackage

FILE: src/elevator_car_controller_top.sv
// Top level: elevator car controller, one scheduler tick in, one status result out.
//
//  channel   dir  fields (lowest bit first)
//  s_axis    in   emergency, sensed_floor, remote_valid, remote_floor, cabin_requests
//  m_axis    out  car_state, car_floor, door_is_open, motor_running, pending_mask
//  cfg       in   door_hold_ticks (write only, no handshake)
//
// Each tick is registered on input, evaluated combinationally against the car state,
// and lands in the output register; one tick per cycle is sustained while m_axis is
// ready. The input register refills while the output register is taken. A stalled
// m_axis holds the result and backs up into s_axis only when both registers are
// full. rst is synchronous: state returns to idle at the top floor, hold to 40.
module elevator_car_controller_top
  import ecc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [0] emergency, [3:1] sensed_floor, [4] remote_valid, [8:5] remote_floor,
  // [12:9] cabin_requests, [15:13] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [2:0] car_state, [5:3] car_floor, [6] door_is_open, [7] motor_running,
  // [11:8] pending_mask, [15:12] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [HOLD_W-1:0]     cfg_wr_data
);

  // Configuration register.
  logic [HOLD_W-1:0] door_hold_ticks;

  // Input register.
  logic                 in_valid;
  logic                 in_emergency;
  logic [FLOOR_W-1:0]   in_sensed;
  logic                 in_rvalid;
  logic [REMOTE_W-1:0]  in_rfloor;
  logic [MASK_W-1:0]    in_cabin;

  // Car state.
  mode_t                mode, mode_next;
  logic [FLOOR_W-1:0]   floor_now, floor_now_next;
  logic [MASK_W-1:0]    pending, pending_next;
  logic [HOLD_W-1:0]    door_count, door_count_next;
  logic                 door_flag, door_flag_next;
  logic                 motor_flag, motor_flag_next;

  // Output register.
  logic                 out_valid;
  logic [OUT_DATA_W-1:0] out_data;

  logic                 advance;
  logic [MASK_W-1:0]    merged;
  logic [MASK_W-1:0]    here_mask;
  logic                 hit;
  logic [FLOOR_W-1:0]   low_floor;
  logic [HOLD_W-1:0]    count_inc;
  logic [STATE_W-1:0]   state_code;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      door_hold_ticks <= DOOR_HOLD_RESET;
    end else if (cfg_wr_en) begin
      door_hold_ticks <= cfg_wr_data;
    end
  end

  // Capture a tick whenever the input register is free or drains this cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_emergency <= s_axis_tdata[0];
      in_sensed    <= s_axis_tdata[3:1];
      in_rvalid    <= s_axis_tdata[4];
      in_rfloor    <= s_axis_tdata[8:5];
      in_cabin     <= s_axis_tdata[12:9];
    end
  end

  // Merge requests: a valid remote floor, then the cabin buttons.
  assign merged = pending
                | (in_rvalid ? floor_onehot(in_rfloor) : '0)
                | (in_cabin & MASK_W'((1 << FLOORS) - 1));

  // Pending bit of the sensed floor, if it is a real floor.
  assign here_mask = floor_onehot(REMOTE_W'(in_sensed)) & merged;

  // Lowest pending floor.
  always_comb begin
    hit       = 1'b0;
    low_floor = '0;
    for (int f = FLOORS; f >= 1; f--) begin
      if (merged[f-1]) begin
        hit       = 1'b1;
        low_floor = FLOOR_W'(f);
      end
    end
  end

  assign count_inc = door_count + HOLD_W'(1);

  always_comb begin
    mode_next       = mode;
    floor_now_next  = floor_now;
    pending_next    = merged;
    door_count_next = door_count;
    door_flag_next  = door_flag;
    motor_flag_next = motor_flag;
    if (in_emergency) begin
      // Latch the emergency; keep floor and doors as they are.
      mode_next       = MODE_EMERG;
      motor_flag_next = 1'b0;
    end else begin
      floor_now_next = in_sensed;
      case (mode)
        MODE_IDLE: begin
          if (hit) begin
            if (low_floor == in_sensed) begin
              pending_next    = merged & ~here_mask;
              mode_next       = MODE_OPEN;
              door_count_next = '0;
            end else if (low_floor > in_sensed) begin
              mode_next       = MODE_UP;
              motor_flag_next = 1'b1;
            end else begin
              mode_next       = MODE_DOWN;
              motor_flag_next = 1'b1;
            end
          end
        end
        MODE_UP, MODE_DOWN: begin
          // Stop at any pending floor passed on the way.
          if (|here_mask) begin
            pending_next    = merged & ~here_mask;
            motor_flag_next = 1'b0;
            mode_next       = MODE_OPEN;
            door_count_next = '0;
          end
        end
        MODE_OPEN: begin
          door_count_next = count_inc;
          door_flag_next  = 1'b1;
          if (count_inc >= door_hold_ticks) begin
            door_flag_next = 1'b0;
            mode_next      = MODE_IDLE;
          end
        end
        default: begin
          // Emergency holds until reset.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      floor_now  <= FLOOR_RESET;
      pending    <= '0;
      door_count <= '0;
      door_flag  <= 1'b0;
      motor_flag <= 1'b0;
    end else if (advance) begin
      mode       <= mode_next;
      floor_now  <= floor_now_next;
      pending    <= pending_next;
      door_count <= door_count_next;
      door_flag  <= door_flag_next;
      motor_flag <= motor_flag_next;
    end
  end

  always_comb begin
    case (mode_next)
      MODE_IDLE:  state_code = CODE_IDLE;
      MODE_UP:    state_code = CODE_UP;
      MODE_DOWN:  state_code = CODE_DOWN;
      MODE_OPEN:  state_code = CODE_OPEN;
      MODE_EMERG: state_code = CODE_EMERG;
      default:    state_code = CODE_EMERG;
    endcase
  end

  // Hold the result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= {4'b0000, pending_next, motor_flag_next, door_flag_next,
                   floor_now_next, state_code};
    end
  end

`include "elevator_car_controller_top_assert.svh"

  `ECC_ASSERT_NOW(a_motor_only_moving, motor_flag, (mode == MODE_UP) || (mode == MODE_DOWN), "motor runs outside a travel state")
  `ECC_ASSERT_NOW(a_door_only_open, door_flag, (mode == MODE_OPEN) || (mode == MODE_EMERG), "door flag set outside door or emergency state")
  `ECC_ASSERT_NEXT(a_emerg_latched, mode == MODE_EMERG, mode == MODE_EMERG, "emergency state left without reset")
  `ECC_ASSERT_NEXT(a_advance_result, advance, m_axis_tvalid, "evaluated tick produced no result")

endmodule

FILE: tb/car_status_checker.sv
// Checker: predicts the car status for every accepted tick and compares it with the results.
module car_status_checker
  import ecc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_wr_en,
  input  logic [HOLD_W-1:0]     cfg_wr_data,
  output int                    mismatches,
  output int                    awaited,
  output int                    statuses_checked
);

  // Result layout, lowest field last so a cast of tdata lines up.
  typedef struct packed {
    logic [3:0]         reserved;
    logic [MASK_W-1:0]  pending;
    logic               motor;
    logic               door;
    logic [FLOOR_W-1:0] floor_at;
    logic [STATE_W-1:0] state;
  } car_status_t;

  car_status_t status_q[$];
  car_status_t got, want;

  mode_t              car_mode;
  logic [FLOOR_W-1:0] car_at;
  logic [MASK_W-1:0]  requests;
  logic [HOLD_W-1:0]  open_ticks;
  logic               door_open;
  logic               motor_on;
  logic [HOLD_W-1:0]  hold_ticks;

  initial begin
    mismatches       = 0;
    awaited          = 0;
    statuses_checked = 0;
  end

  task automatic check_field(input string field, input int want_v, input int got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
      mismatches++;
    end
  endtask

  // Advance the car by one tick and return its status.
  task automatic advance_car(input logic [IN_DATA_W-1:0] d, output car_status_t st);
    logic               emerg;
    logic [FLOOR_W-1:0] sensed;
    logic               rvalid;
    logic [3:0]         rfloor;
    logic [MASK_W-1:0]  cabin;
    bit                 found;
    emerg  = d[0];
    sensed = d[3:1];
    rvalid = d[4];
    rfloor = d[8:5];
    cabin  = d[12:9];
    found  = 0;

    // Merge new requests first; remote floors outside the shaft are dropped.
    if (rvalid && rfloor >= 1 && rfloor <= FLOORS)
      requests[rfloor - 1] = 1'b1;
    requests = requests | cabin;

    if (emerg) begin
      car_mode = MODE_EMERG;
      motor_on = 1'b0;
    end else begin
      car_at = sensed;
      case (car_mode)
        MODE_IDLE: begin
          // Serve the lowest pending floor.
          for (int f = 1; f <= FLOORS; f++) begin
            if (!found && requests[f - 1]) begin
              found = 1;
              if (f == car_at) begin
                requests[f - 1] = 1'b0;
                car_mode   = MODE_OPEN;
                open_ticks = '0;
              end else if (f > car_at) begin
                car_mode = MODE_UP;
                motor_on = 1'b1;
              end else begin
                car_mode = MODE_DOWN;
                motor_on = 1'b1;
              end
            end
          end
        end
        MODE_UP, MODE_DOWN: begin
          if (car_at >= 1 && car_at <= FLOORS && requests[car_at - 1]) begin
            requests[car_at - 1] = 1'b0;
            motor_on   = 1'b0;
            car_mode   = MODE_OPEN;
            open_ticks = '0;
          end
        end
        MODE_OPEN: begin
          door_open  = 1'b1;
          open_ticks = open_ticks + 1'b1;
          if (open_ticks >= hold_ticks) begin
            door_open = 1'b0;
            car_mode  = MODE_IDLE;
          end
        end
        default: ;
      endcase
    end

    st = '0;
    case (car_mode)
      MODE_IDLE: st.state = CODE_IDLE;
      MODE_UP:   st.state = CODE_UP;
      MODE_DOWN: st.state = CODE_DOWN;
      MODE_OPEN: st.state = CODE_OPEN;
      default:   st.state = CODE_EMERG;
    endcase
    st.floor_at = car_at;
    st.door     = door_open;
    st.motor    = motor_on;
    st.pending  = requests;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      car_mode   = MODE_IDLE;
      car_at     = FLOOR_RESET;
      requests   = '0;
      open_ticks = '0;
      door_open  = 1'b0;
      motor_on   = 1'b0;
      hold_ticks = DOOR_HOLD_RESET;
      status_q.delete();
    end else begin
      // Retire the result first so a transaction can never match its own tick.
      if (m_axis_tvalid && m_axis_tready) begin
        got = car_status_t'(m_axis_tdata);
        if (status_q.size() == 0) begin
          $display("%0t: unexpected status, expected none, actual %h", $time, m_axis_tdata);
          mismatches++;
        end else begin
          want = status_q.pop_front();
          check_field("car_state", want.state, got.state);
          check_field("car_floor", want.floor_at, got.floor_at);
          check_field("door_is_open", want.door, got.door);
          check_field("motor_running", want.motor, got.motor);
          check_field("pending_mask", want.pending, got.pending);
          check_field("reserved bits", want.reserved, got.reserved);
          statuses_checked++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        advance_car(s_axis_tdata, want);
        status_q.push_back(want);
      end
      if (cfg_wr_en)
        hold_ticks = cfg_wr_data;
    end
    awaited <= status_q.size();
  end

endmodule

FILE: tb/elevator_car_controller_top_test.sv
// Testbench top: drives ticks and hold settings into the car controller and reports the verdict.
module elevator_car_controller_top_test;
  import ecc_pkg::*;

  // Generous ceiling: a few hundred ticks with random gaps and stalls need well under this.
  localparam int CYCLE_LIMIT = 200000;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wr_en     = 1'b0;
  logic [HOLD_W-1:0]     cfg_wr_data   = '0;

  // High while a stretch runs with no idling on either side.
  logic quiet = 1'b0;

  int cycles        = 0;
  int ticks_sent    = 0;
  int hold_settings = 0;
  // Stimulus car position in half floors: even values sit at floor walk_pos/2,
  // odd values are between floors.
  int walk_pos      = 8;
  int mismatches;
  int awaited;
  int statuses_checked;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  elevator_car_controller_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  car_status_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatches       (mismatches),
    .awaited          (awaited),
    .statuses_checked (statuses_checked)
  );

  // Stall the result side at random, about 22 percent of the time, never in a quiet stretch.
  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= 22);
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d statuses outstanding", cycles, awaited);
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one tick and hold it until the transaction completes; then idle at random.
  // Call at a rising edge.
  task automatic push_tick(input logic emerg, input logic [FLOOR_W-1:0] sensed,
                           input logic rvalid, input logic [3:0] rfloor,
                           input logic [MASK_W-1:0] cabin);
    s_axis_tdata  <= {3'b000, cabin, rfloor, rvalid, sensed, emerg};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    ticks_sent++;
    if (!quiet && $urandom_range(99) < 22) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  // Drop valid, wait until every predicted status has come back, then let the pipe settle.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the door hold register; only called with the block drained.
  task automatic set_hold(input logic [HOLD_W-1:0] hold);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= hold;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    hold_settings++;
  endtask

  // Mostly a car that creeps floor by floor with sparse requests; some pure noise.
  task automatic random_tick(input logic emerg);
    logic [FLOOR_W-1:0] sensed;
    logic               rvalid;
    logic [3:0]         rfloor;
    logic [MASK_W-1:0]  cabin;
    if ($urandom_range(99) < 10) begin
      sensed = 3'($urandom);
      rvalid = 1'($urandom);
      rfloor = 4'($urandom);
      cabin  = 4'($urandom);
    end else begin
      if ($urandom_range(99) < 35)
        walk_pos = $urandom_range(1) ? walk_pos + 1 : walk_pos - 1;
      if (walk_pos < 2)
        walk_pos = 3;
      if (walk_pos > 2 * FLOORS)
        walk_pos = 2 * FLOORS - 1;
      sensed = walk_pos[0] ? 3'd0 : 3'(walk_pos / 2);
      cabin  = ($urandom_range(99) < 20) ? 4'($urandom) : 4'd0;
      rvalid = ($urandom_range(99) < 15);
      rfloor = ($urandom_range(99) < 85) ? 4'($urandom_range(FLOORS, 1)) : 4'($urandom);
    end
    push_tick(emerg, sensed, rvalid, rfloor, cabin);
  endtask

  // One phase: drain, set the hold, then random ticks.
  // calm: no idling on either side; alarm: emergencies allowed (they latch for good);
  // pause: stop halfway until all statuses are back.
  task automatic run_phase(input logic [HOLD_W-1:0] hold, input int n, input bit calm,
                           input bit alarm, input bit pause);
    drain_results();
    set_hold(hold);
    quiet <= calm;
    for (int i = 0; i < n; i++) begin
      if (pause && i == n / 2)
        drain_results();
      random_tick(alarm && (i == n / 2 || $urandom_range(99) < 6));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset hold of 40: car starts idle at the top floor.
    push_tick(1'b0, 3'd0, 1'b0, 4'd0,  4'b0000); // idle between floors, nothing pending
    push_tick(1'b0, 3'd4, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd4, 1'b0, 4'd0,  4'b1000); // request the current floor: doors open
    push_tick(1'b0, 3'd4, 1'b1, 4'd15, 4'b0000); // remote floor out of range: dropped
    push_tick(1'b0, 3'd4, 1'b1, 4'd5,  4'b0000);
    push_tick(1'b0, 3'd4, 1'b1, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd4, 1'b0, 4'd1,  4'b0000); // remote floor without valid: dropped
    push_tick(1'b0, 3'd7, 1'b1, 4'd1,  4'b1111); // sensor above the shaft, all buttons

    // Lower the hold while the doors are still open: they close on the next tick.
    drain_results();
    set_hold(16'd1);
    push_tick(1'b0, 3'd4, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd0, 1'b0, 4'd0,  4'b0000); // idle between floors: pending above
    push_tick(1'b0, 3'd1, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd1, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd2, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd2, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd3, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd6, 1'b1, 4'd2,  4'b0000); // unknown floor: pending below
    push_tick(1'b0, 3'd5, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd3, 1'b1, 4'd4,  4'b0001);
    push_tick(1'b0, 3'd2, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd1, 1'b0, 4'd0,  4'b0000);
    push_tick(1'b0, 3'd4, 1'b0, 4'd0,  4'b0000);

    // Random phases over several hold settings, extremes included.
    run_phase(16'd40,    70,  1'b0, 1'b0, 1'b0);
    run_phase(16'd0,     50,  1'b0, 1'b0, 1'b0);
    run_phase(16'd3,     60,  1'b0, 1'b0, 1'b1);
    run_phase(16'd1,     130, 1'b1, 1'b0, 1'b0);
    run_phase(16'd65535, 40,  1'b0, 1'b0, 1'b0);
    run_phase(16'd2,     60,  1'b0, 1'b0, 1'b0);
    run_phase(16'd9,     60,  1'b0, 1'b0, 1'b0);
    // Emergency last: it holds until reset.
    run_phase(16'd4,     50,  1'b0, 1'b1, 1'b0);

    quiet <= 1'b0;
    drain_results();

    $display("Covered %0d ticks across %0d door hold settings, emergency latch included;",
             ticks_sent, hold_settings + 1);
    $display("%0d status results checked, %0d mismatches.", statuses_checked, mismatches);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
